[src/cite_pkg.sv]
// ----------------------------------------------------------------------------
// cite_pkg
// Shared types, sizes and mnemonic tables for the C-instruction text encoder.
// ----------------------------------------------------------------------------
package cite_pkg;

    localparam int SECTION_CHARS = 3;
    localparam int TEXT_W        = 8 * SECTION_CHARS;
    localparam int LEN_W         = $clog2(SECTION_CHARS + 1);

    localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] CH_J    = 8'h4A;  // 'J'
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [2:0] C_PREFIX = 3'b111;

    typedef logic [TEXT_W-1:0] t_text;
    typedef logic [LEN_W-1:0]  t_len;

    typedef enum logic [1:0] {
        SEC_LEAD = 2'd0,  // first section
        SEC_MID  = 2'd1,  // after '='
        SEC_TAIL = 2'd2,  // after '=' and ';'
        SEC_JUMP = 2'd3   // after ';' with no '='
    } t_section;

    // token state as seen after the current character
    typedef struct packed {
        t_text    lead;
        t_text    mid;
        t_text    tail;
        t_section section;
        logic     too_long;
        logic     jump_off;
    } t_tok;

    typedef struct packed {
        logic       hit;
        logic [2:0] val;
    } t_hit3;

    typedef struct packed {
        logic       hit;
        logic [6:0] val;
    } t_hit7;

    function automatic t_hit3 dest_lookup(input t_text txt);
        t_hit3 r;
        r = '{hit: 1'b1, val: 3'd0};
        case (txt)
            t_text'(24'h004D44): r.val = 3'd3;  // MD
            t_text'(24'h00414D): r.val = 3'd5;  // AM
            t_text'(24'h004144): r.val = 3'd6;  // AD
            t_text'(24'h414D44): r.val = 3'd7;  // AMD
            t_text'(24'h000041): r.val = 3'd4;  // A
            t_text'(24'h00004D): r.val = 3'd1;  // M
            t_text'(24'h000044): r.val = 3'd2;  // D
            default:             r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_hit7 comp_lookup(input t_text txt);
        t_hit7 r;
        r = '{hit: 1'b1, val: 7'd0};
        case (txt)
            t_text'(24'h000041): r.val = 7'h30;  // A
            t_text'(24'h00004D): r.val = 7'h70;  // M
            t_text'(24'h000044): r.val = 7'h0C;  // D
            t_text'(24'h000030): r.val = 7'h2A;  // 0
            t_text'(24'h000031): r.val = 7'h3F;  // 1
            t_text'(24'h002D31): r.val = 7'h3A;  // -1
            t_text'(24'h002144): r.val = 7'h0D;  // !D
            t_text'(24'h002141): r.val = 7'h31;  // !A
            t_text'(24'h002D44): r.val = 7'h0F;  // -D
            t_text'(24'h002D41): r.val = 7'h33;  // -A
            t_text'(24'h442B31): r.val = 7'h1F;  // D+1
            t_text'(24'h412B31): r.val = 7'h37;  // A+1
            t_text'(24'h442D31): r.val = 7'h0E;  // D-1
            t_text'(24'h412D31): r.val = 7'h32;  // A-1
            t_text'(24'h442B41): r.val = 7'h02;  // D+A
            t_text'(24'h442D41): r.val = 7'h13;  // D-A
            t_text'(24'h412D44): r.val = 7'h07;  // A-D
            t_text'(24'h442641): r.val = 7'h00;  // D&A
            t_text'(24'h447C41): r.val = 7'h15;  // D|A
            t_text'(24'h00214D): r.val = 7'h71;  // !M
            t_text'(24'h002D4D): r.val = 7'h73;  // -M
            t_text'(24'h4D2B31): r.val = 7'h77;  // M+1
            t_text'(24'h4D2D31): r.val = 7'h72;  // M-1
            t_text'(24'h442B4D): r.val = 7'h42;  // D+M
            t_text'(24'h442D4D): r.val = 7'h53;  // D-M
            t_text'(24'h4D2D44): r.val = 7'h47;  // M-D
            t_text'(24'h44264D): r.val = 7'h40;  // D&M
            t_text'(24'h447C4D): r.val = 7'h55;  // D|M
            default:             r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_hit3 jump_lookup(input t_text txt);
        t_hit3 r;
        r = '{hit: 1'b1, val: 3'd0};
        case (txt)
            t_text'(24'h4A4D50): r.val = 3'd7;  // JMP
            t_text'(24'h4A4C54): r.val = 3'd4;  // JLT
            t_text'(24'h4A4C45): r.val = 3'd6;  // JLE
            t_text'(24'h4A4754): r.val = 3'd1;  // JGT
            t_text'(24'h4A4745): r.val = 3'd3;  // JGE
            t_text'(24'h4A4551): r.val = 3'd2;  // JEQ
            t_text'(24'h4A4E45): r.val = 3'd5;  // JNE
            default:             r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[src/cite_accum.sv]
// ----------------------------------------------------------------------------
// cite_accum
// Section tracker and text collector; shows the token state after the
// current character and clears itself when a last beat is taken.
// ----------------------------------------------------------------------------
module cite_accum
    import cite_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output t_tok       o_tok
);

    t_text    r_lead, r_mid, r_tail;
    t_len     r_len;
    t_section r_section;
    logic     r_too_long, r_jump_off;

    t_text    n_lead, n_mid, n_tail;
    t_len     n_len;
    t_section n_section;
    logic     n_too_long, n_jump_off;

    logic is_eq, is_semi, in_jump, full;

    always_comb begin
        n_lead     = r_lead;
        n_mid      = r_mid;
        n_tail     = r_tail;
        n_len      = r_len;
        n_section  = r_section;
        n_too_long = r_too_long;
        n_jump_off = r_jump_off;

        is_eq   = (i_ch == CH_EQ) && (r_section == SEC_LEAD);
        is_semi = (i_ch == CH_SEMI) && (r_section == SEC_LEAD || r_section == SEC_MID);
        in_jump = (r_section == SEC_TAIL) || (r_section == SEC_JUMP);
        full    = (r_len >= t_len'(SECTION_CHARS));

        if (is_eq || is_semi) begin
            // a trailing sign is simply dropped
            if (!i_last) begin
                if (is_eq) begin
                    n_section = SEC_MID;
                end else if (r_section == SEC_LEAD) begin
                    n_section = SEC_JUMP;
                end else begin
                    n_section = SEC_TAIL;
                end
                n_len = '0;
            end
        end else begin
            if (in_jump && r_len == '0 && !r_jump_off && i_ch != CH_J) begin
                n_jump_off = 1'b1;
            end
            if (!(in_jump && n_jump_off)) begin
                if (i_ch == CH_NUL || full) begin
                    n_too_long = 1'b1;
                end else begin
                    n_len = r_len + t_len'(1);
                    if (in_jump) begin
                        n_tail = {r_tail[TEXT_W-9:0], i_ch};
                    end else if (r_section == SEC_MID) begin
                        n_mid = {r_mid[TEXT_W-9:0], i_ch};
                    end else begin
                        n_lead = {r_lead[TEXT_W-9:0], i_ch};
                    end
                end
            end
        end
    end

    assign o_tok = '{lead: n_lead, mid: n_mid, tail: n_tail, section: n_section,
                     too_long: n_too_long, jump_off: n_jump_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead     <= '0;
            r_mid      <= '0;
            r_tail     <= '0;
            r_len      <= '0;
            r_section  <= SEC_LEAD;
            r_too_long <= 1'b0;
            r_jump_off <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_lead     <= '0;
                r_mid      <= '0;
                r_tail     <= '0;
                r_len      <= '0;
                r_section  <= SEC_LEAD;
                r_too_long <= 1'b0;
                r_jump_off <= 1'b0;
            end else begin
                r_lead     <= n_lead;
                r_mid      <= n_mid;
                r_tail     <= n_tail;
                r_len      <= n_len;
                r_section  <= n_section;
                r_too_long <= n_too_long;
                r_jump_off <= n_jump_off;
            end
        end
    end

endmodule

[src/cite_decode.sv]
// ----------------------------------------------------------------------------
// cite_decode
// Mnemonic lookup and word assembly for a finished token.
// ----------------------------------------------------------------------------
module cite_decode
    import cite_pkg::*;
(
    input  t_tok        i_tok,
    output logic [15:0] o_code,
    output logic        o_error
);

    logic  has_dest, has_jump;
    t_hit3 dest_r, jump_r;
    t_hit7 comp_r;
    logic  err;

    always_comb begin
        has_dest = (i_tok.section == SEC_MID) || (i_tok.section == SEC_TAIL);
        has_jump = ((i_tok.section == SEC_TAIL) || (i_tok.section == SEC_JUMP))
                   && !i_tok.jump_off;

        dest_r = dest_lookup(i_tok.lead);
        comp_r = comp_lookup(has_dest ? i_tok.mid : i_tok.lead);
        jump_r = jump_lookup(i_tok.tail);

        err = i_tok.too_long || !comp_r.hit
              || (has_dest && !dest_r.hit) || (has_jump && !jump_r.hit);

        o_error = err;
        if (err) begin
            o_code = '0;
        end else begin
            o_code = {C_PREFIX, comp_r.val,
                      has_dest ? dest_r.val : 3'd0,
                      has_jump ? jump_r.val : 3'd0};
        end
    end

endmodule

[src/c_instruction_text_encoder.sv]
// ----------------------------------------------------------------------------
// c_instruction_text_encoder
// Character-serial encoder for C-instruction tokens (dest=comp;jump).
// ----------------------------------------------------------------------------
//  channel | valid      | ready      | payload           | beat carries
//  --------+------------+------------+-------------------+----------------------
//  input   | i_in_valid | o_in_ready | i_ch, i_last      | one token character
//  output  | o_out_valid| i_out_ready| o_code, o_error   | one encoded word
//
//  One character per cycle, save for the stall described below. A character
//  is held in the input register, then updates the section state; a last
//  character also writes the encoded word into the output register in that
//  same cycle.
//  Reset (synchronous, active low) empties both registers and the token state.
//  Only a last character needs the output slot: while a word is held
//  unread, a waiting last character stalls the input; others flow on.
// ----------------------------------------------------------------------------
module c_instruction_text_encoder
    import cite_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code,
    output logic        o_error
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_ch;
    logic        r_in_last;

    // output register
    logic        r_out_valid;
    logic [15:0] r_code;
    logic        r_error;

    logic        advance;
    t_tok        tok;
    logic [15:0] dec_code;
    logic        dec_error;

    // a held character moves on unless it is a last one facing a full slot
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cite_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_ch    (r_in_ch),
        .i_last  (r_in_last),
        .o_tok   (tok)
    );

    cite_decode u_decode (
        .i_tok   (tok),
        .o_code  (dec_code),
        .o_error (dec_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_ch   <= i_ch;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_code  <= dec_code;
            r_error <= dec_error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code      = r_code;
    assign o_error     = r_error;

    // input stalls only for a last character behind an unread word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in_last && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked last character");

    // an error word carries no code bits
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_code == 16'h0000))
        else $error("error word with nonzero code");

    // a good word always has the C-instruction prefix
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_error) |-> (o_code[15:13] == C_PREFIX))
        else $error("good word without C prefix");

    // a word is produced exactly when a last character moves on
    a_word_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> o_out_valid)
        else $error("last character did not load a word");

endmodule

[verif/c_instruction_text_encoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_instruction_text_encoder_test
// Drives C-instruction tokens one character per beat into the encoder,
// predicts each encoded word from its own model of the section state, and
// checks every word leaving the block in order under random idling on
// both channels.
// ----------------------------------------------------------------------------
import cite_pkg::*;

// Keeps the token state of the encoder and the queue of words still due.
class word_scoreboard;

    typedef struct {
        logic [15:0] code;
        logic        error;
    } t_word;

    t_word       words_due[$];
    t_text       lead_txt;
    t_text       mid_txt;
    t_text       tail_txt;
    t_len        used;
    t_section    sec;
    logic        overlong;
    logic        no_jump;
    int unsigned failures;
    int unsigned mismatches;

    function new();
        clear_token();
        failures   = 0;
        mismatches = 0;
    endfunction

    function void clear_token();
        lead_txt = '0;
        mid_txt  = '0;
        tail_txt = '0;
        used     = '0;
        sec      = SEC_LEAD;
        overlong = 1'b0;
        no_jump  = 1'b0;
    endfunction

    function int pending();
        return words_due.size();
    endfunction

    // One accepted input beat; a last character closes the token and
    // queues the word it encodes.
    function void note_beat(logic [7:0] c, logic lst);
        logic       is_eq;
        logic       is_semi;
        logic       in_jump;
        logic       has_dest;
        logic       bad;
        logic [2:0] dv;
        logic [6:0] cv;
        logic [2:0] jv;
        t_text      comp_txt;
        t_word      w;

        is_eq   = (c == CH_EQ) && (sec == SEC_LEAD);
        is_semi = (c == CH_SEMI) && (sec == SEC_LEAD || sec == SEC_MID);
        if (is_eq || is_semi) begin
            // a trailing sign is simply dropped
            if (!lst) begin
                sec  = is_eq ? SEC_MID : ((sec == SEC_LEAD) ? SEC_JUMP : SEC_TAIL);
                used = '0;
            end
        end else begin
            in_jump = (sec == SEC_TAIL) || (sec == SEC_JUMP);
            if (in_jump && used == 0 && !no_jump && c != CH_J)
                no_jump = 1'b1;
            if (!(in_jump && no_jump)) begin
                if (c == CH_NUL || used >= SECTION_CHARS) begin
                    overlong = 1'b1;
                end else begin
                    case (sec)
                        SEC_LEAD: lead_txt = (lead_txt << 8) | t_text'(c);
                        SEC_MID:  mid_txt  = (mid_txt << 8) | t_text'(c);
                        default:  tail_txt = (tail_txt << 8) | t_text'(c);
                    endcase
                    used++;
                end
            end
        end
        if (!lst)
            return;

        has_dest = (sec == SEC_MID) || (sec == SEC_TAIL);
        bad      = overlong;
        dv       = 3'd0;
        cv       = 7'd0;
        jv       = 3'd0;

        if (has_dest) begin
            case (lead_txt)
                t_text'("M"):   dv = 3'd1;
                t_text'("D"):   dv = 3'd2;
                t_text'("MD"):  dv = 3'd3;
                t_text'("A"):   dv = 3'd4;
                t_text'("AM"):  dv = 3'd5;
                t_text'("AD"):  dv = 3'd6;
                t_text'("AMD"): dv = 3'd7;
                default:        bad = 1'b1;
            endcase
        end

        comp_txt = has_dest ? mid_txt : lead_txt;
        case (comp_txt)
            t_text'("0"):   cv = 7'h2A;
            t_text'("1"):   cv = 7'h3F;
            t_text'("-1"):  cv = 7'h3A;
            t_text'("D"):   cv = 7'h0C;
            t_text'("A"):   cv = 7'h30;
            t_text'("M"):   cv = 7'h70;
            t_text'("!D"):  cv = 7'h0D;
            t_text'("!A"):  cv = 7'h31;
            t_text'("!M"):  cv = 7'h71;
            t_text'("-D"):  cv = 7'h0F;
            t_text'("-A"):  cv = 7'h33;
            t_text'("-M"):  cv = 7'h73;
            t_text'("D+1"): cv = 7'h1F;
            t_text'("A+1"): cv = 7'h37;
            t_text'("M+1"): cv = 7'h77;
            t_text'("D-1"): cv = 7'h0E;
            t_text'("A-1"): cv = 7'h32;
            t_text'("M-1"): cv = 7'h72;
            t_text'("D+A"): cv = 7'h02;
            t_text'("D+M"): cv = 7'h42;
            t_text'("D-A"): cv = 7'h13;
            t_text'("D-M"): cv = 7'h53;
            t_text'("A-D"): cv = 7'h07;
            t_text'("M-D"): cv = 7'h47;
            t_text'("D&A"): cv = 7'h00;
            t_text'("D&M"): cv = 7'h40;
            t_text'("D|A"): cv = 7'h15;
            t_text'("D|M"): cv = 7'h55;
            default:        bad = 1'b1;
        endcase

        // a jump text not led by J is ignored altogether
        if ((sec == SEC_TAIL || sec == SEC_JUMP) && !no_jump) begin
            case (tail_txt)
                t_text'("JGT"): jv = 3'd1;
                t_text'("JEQ"): jv = 3'd2;
                t_text'("JGE"): jv = 3'd3;
                t_text'("JLT"): jv = 3'd4;
                t_text'("JNE"): jv = 3'd5;
                t_text'("JLE"): jv = 3'd6;
                t_text'("JMP"): jv = 3'd7;
                default:        bad = 1'b1;
            endcase
        end

        w.code  = bad ? 16'h0000 : {C_PREFIX, cv, dv, jv};
        w.error = bad;
        words_due.push_back(w);
        clear_token();
    endfunction

    // One accepted output beat, compared with the oldest word due.
    function void check_word(logic [15:0] code, logic err);
        t_word w;

        if (words_due.size() == 0) begin
            failures++;
            if (mismatches < 10)
                $display("unexpected word: code=%h error=%b", code, err);
            mismatches++;
        end else begin
            w = words_due.pop_front();
            if (w.code !== code || w.error !== err) begin
                failures++;
                if (mismatches < 10)
                    $display("word mismatch: expected code=%h error=%b, got code=%h error=%b",
                             w.code, w.error, code, err);
                mismatches++;
            end
        end
    endfunction

endclass

module c_instruction_text_encoder_test;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 6;
    localparam int BEAT_TARGET = 1350;
    localparam int TAIL_CYCLES = 8;       // leave some slack after the last word
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_ch        = 8'h00;
    logic        i_last      = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [15:0] o_code;
    logic        o_error;

    word_scoreboard sb;

    // token under construction, one character per entry
    logic [7:0]  tok[$];
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    int unsigned rx_cycle   = 0;
    int unsigned cycles     = 0;

    string dest_m[7]  = '{"M", "D", "MD", "A", "AM", "AD", "AMD"};
    string jump_m[7]  = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
    string comp_m[28] = '{"0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D",
                          "-A", "-M", "D+1", "A+1", "M+1", "D-1", "A-1", "M-1",
                          "D+A", "D+M", "D-A", "D-M", "A-D", "M-D", "D&A", "D&M",
                          "D|A", "D|M"};
    // characters that tend to land near real mnemonics
    string near_chars = "AMD01-+!&|=;JLTGEQNPX";

    c_instruction_text_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code      (o_code),
        .o_error     (o_error)
    );

    // 12 ns clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Monitor: both channels sampled at the rising edge, so values seen
    // here are the ones that were settled before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_word(o_code, o_error);
            if (i_in_valid && o_in_ready)
                sb.note_beat(i_ch, i_last);
        end
    end

    // Watchdog, far above the slowest legal run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: cycles through four stall patterns in equal stretches:
    // always ready, coin flip, a fixed three-quarter duty, and long runs low.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= (rx_cycle % 16) < 12;
            default: i_out_ready <= ((rx_cycle / 23) % 3) != 0;
        endcase
    end

    function void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            tok.push_back(s[k]);
    endfunction

    // Send one beat. Bursts of random length with random gaps between;
    // some bursts are long so that stretches run without any idling.
    task send_beat(logic [7:0] c, logic lst);
        int unsigned gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_last     <= lst;
        burst_left--;
        beats_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task send_token();
        foreach (tok[i])
            send_beat(tok[i], i == tok.size() - 1);
    endtask

    // Hold the input low until every queued word has left the block.
    task drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // Build one random token: mostly well-formed dest=comp;jump with
    // random parts, some broken on purpose, the rest jump-off, trailing
    // signs or plain noise.
    task make_token();
        int unsigned kind;
        int unsigned pos;
        int unsigned n;

        tok.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            if ($urandom_range(0, 3) != 0) begin
                add_text(dest_m[$urandom_range(0, 6)]);
                add_text("=");
            end
            add_text(comp_m[$urandom_range(0, 27)]);
            if ($urandom_range(0, 1) != 0) begin
                add_text(";");
                add_text(jump_m[$urandom_range(0, 6)]);
            end
            // break a few: overwrite, lengthen or shorten
            if ($urandom_range(0, 6) == 0) begin
                pos = $urandom_range(0, tok.size() - 1);
                case ($urandom_range(0, 2))
                    0: tok[pos] = near_chars[$urandom_range(0, near_chars.len() - 1)];
                    1: tok.insert(pos, near_chars[$urandom_range(0, near_chars.len() - 1)]);
                    default: if (tok.size() > 1) tok.delete(pos);
                endcase
            end
        end else if (kind < 80) begin
            // jump text not led by J, content ignored by the block
            if ($urandom_range(0, 1) != 0) begin
                add_text(dest_m[$urandom_range(0, 6)]);
                add_text("=");
            end
            add_text(comp_m[$urandom_range(0, 27)]);
            add_text(";");
            n = $urandom_range(1, 5);
            repeat (n)
                tok.push_back(($urandom_range(0, 1) != 0)
                              ? near_chars[$urandom_range(0, near_chars.len() - 1)]
                              : 8'($urandom_range(0, 255)));
        end else if (kind < 86) begin
            // token closed by a sign
            if ($urandom_range(0, 1) != 0) begin
                add_text(dest_m[$urandom_range(0, 6)]);
                add_text("=");
                add_text(comp_m[$urandom_range(0, 27)]);
                add_text(";");
            end else begin
                add_text(($urandom_range(0, 1) != 0) ? dest_m[$urandom_range(0, 6)]
                                                     : comp_m[$urandom_range(0, 27)]);
                add_text(($urandom_range(0, 1) != 0) ? "=" : ";");
            end
        end else begin
            n = $urandom_range(1, 7);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0:       tok.push_back(CH_NUL);
                    1, 2, 3, 4:
                             tok.push_back(8'($urandom_range(0, 255)));
                    default: tok.push_back(near_chars[$urandom_range(0, near_chars.len() - 1)]);
                endcase
            end
        end
    endtask

    // Directed tokens: full form, trailing '=' and ';', jump without J,
    // a repeated sign, an empty dest, a NUL, an overlong comp, and the
    // top character code.
    string directed_m[8] = '{"AMD=M+1;JGE", "D=", "D;", "0;X", "==", "=D",
                             "D+1A", "D|M;JMP"};
    logic  mid_drained = 1'b0;

    initial begin
        sb = new();

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_m[i]) begin
            tok.delete();
            add_text(directed_m[i]);
            send_token();
        end
        tok.delete();
        tok.push_back(CH_NUL);
        send_token();
        tok.delete();
        tok.push_back(8'hFF);
        send_token();
        drain();

        while (beats_sent < BEAT_TARGET) begin
            make_token();
            send_token();
            if (!mid_drained && beats_sent > BEAT_TARGET / 2) begin
                mid_drained = 1'b1;
                drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
